FILE: hdl/assert_macros.svh
// Assertion helpers for the estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is held.
`define EVS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property, also checked during reset.
`define EVS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/evs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder velocity estimator package
// Shared widths, register indexes, the divider status type and the saturation helper.
// ----------------------------------------------------------------------------
package evs_pkg;

    localparam int VelW        = 48;
    localparam int FracBitsDef = 16;
    localparam int ProdW       = 51;
    localparam int WgtW        = 17;
    localparam int DivDenW     = 32;

    localparam logic [19:0] UsPerSec = 20'd1000000;
    localparam logic [16:0] WeightOne = 17'd65536;

    localparam logic [1:0] RegTicksPerSec = 2'd0;
    localparam logic [1:0] RegStopTimeout = 2'd1;
    localparam logic [1:0] RegWindowLen   = 2'd2;
    localparam logic [1:0] RegBlendCounts = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } t_div_stat;

    // Clamp an unsigned magnitude to the signed velocity range and apply the sign.
    function automatic logic [VelW-1:0] sat_vel(input logic neg, input logic big,
                                                 input logic [VelW-1:0] mag);
        logic [VelW-1:0] res;
        if (big || mag[VelW-1]) begin
            res = neg ? {1'b1, {(VelW-1){1'b0}}} : {1'b0, {(VelW-1){1'b1}}};
        end else begin
            res = neg ? (~mag + 1'b1) : mag;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/evs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider, one quotient bit per cycle over a left-aligned dividend.
// ----------------------------------------------------------------------------
module evs_div #(
    parameter int DIVW = 68
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [DIVW-1:0]                i_dividend,
    input  wire logic [$clog2(DIVW+1)-1:0]      i_len,
    input  wire logic [evs_pkg::DivDenW-1:0]    i_divisor,
    output logic      [evs_pkg::VelW-1:0]       o_quot,
    output evs_pkg::t_div_stat                  o_stat
);
    localparam int CntW = $clog2(DIVW+1);
    localparam int DW   = evs_pkg::DivDenW;
    localparam int QW   = evs_pkg::VelW;

    logic [DIVW-1:0] r_num;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [QW-1:0]   r_q;
    logic            r_ovf;
    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_num[DIVW-1]};
        diff  = trial - {1'b0, r_den};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
            r_ovf <= r_ovf | r_q[QW-1];
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;

endmodule
`default_nettype wire

FILE: hdl/encoder_velocity_estimator.sv
// Each request steps through the period division, the window count division and the
// weight division where they apply, then, for a blend, the serial multiply and its
// rounding; all divisions run on the one bit-serial divider.
// One request is in work at a time; the next is taken in the cycle after the result is
// registered, and a result still waiting in the output register holds the last step.
// Reset is synchronous, active low, and restores the register defaults and clears the window.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Encoder velocity estimator
// Blends a period estimate and a windowed count estimate with one shared divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module encoder_velocity_estimator #(
    parameter int FRACTION_BITS = evs_pkg::FracBitsDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_now_ticks,
    input  wire logic [31:0] i_now_us,
    input  wire logic [31:0] i_last_edge_ticks,
    input  wire logic [31:0] i_last_period_ticks,
    input  wire logic signed [1:0]  i_edge_direction,
    input  wire logic signed [31:0] i_position_count,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [47:0] o_velocity,
    output logic             o_velocity_valid
);
    localparam int VW   = evs_pkg::VelW;
    localparam int DIVW = evs_pkg::ProdW + 1 + FRACTION_BITS;
    localparam int CntW = $clog2(DIVW+1);
    localparam int PerW = 33 + FRACTION_BITS;
    localparam int AccW = 66;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_PER   = 12'b0000_0000_0010,
        S_PWAIT = 12'b0000_0000_0100,
        S_PROD  = 12'b0000_0000_1000,
        S_CNT   = 12'b0000_0001_0000,
        S_CWAIT = 12'b0000_0010_0000,
        S_WGT   = 12'b0000_0100_0000,
        S_WWAIT = 12'b0000_1000_0000,
        S_MINIT = 12'b0001_0000_0000,
        S_MUL   = 12'b0010_0000_0000,
        S_RND   = 12'b0100_0000_0000,
        S_FIN   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;

    logic [31:0] r_tps;
    logic [30:0] r_stop;
    logic [31:0] r_wl;
    logic [15:0] r_bc;

    logic [31:0] r_wstart;
    logic [31:0] r_wcount;
    logic [VW-1:0] r_blended;
    logic        r_has;

    logic [31:0] r_nt, r_nus, r_edge, r_per, r_pos;
    logic [1:0]  r_dir;
    logic [VW-1:0] r_vper, r_vcnt, r_blend;
    logic [31:0] r_dmag;
    logic        r_dneg;
    logic [evs_pkg::ProdW-1:0] r_prod;
    logic [evs_pkg::WgtW-1:0]  r_a;
    logic [AccW-1:0] r_acc, r_md;
    logic [4:0]  r_mcnt;

    logic          r_ovalid;
    logic [VW-1:0] r_ovel;
    logic          r_ovv;

    // Derived conditions of the request in work.
    logic        stale, per_ok, started, elapsed;
    logic [31:0] dt, dc, dmag, age;
    logic [15:0] bce;
    logic [VW:0] vdiff;
    logic [AccW-1:0] rnd_mag;
    logic [AccW-1:0] rnd_sum;
    logic [AccW-17:0] rnd_q;
    logic [VW-1:0] rnd_res;

    always_comb begin
        age     = r_nt - r_edge;
        stale   = (r_edge == '0) || (age > {1'b0, r_stop});
        per_ok  = !stale && (r_per != '0) && (r_dir != '0);
        started = r_wstart != '0;
        dt      = r_nus - r_wstart;
        elapsed = started && (dt >= r_wl);
        dc      = r_pos - r_wcount;
        dmag    = dc[31] ? (~dc + 1'b1) : dc;
        bce     = (r_bc == '0) ? 16'd1 : r_bc;
        vdiff   = {r_vcnt[VW-1], r_vcnt} - {r_vper[VW-1], r_vper};
        rnd_mag = r_acc[AccW-1] ? (~r_acc + 1'b1) : r_acc;
        rnd_sum = rnd_mag + AccW'(32768);
        rnd_q   = rnd_sum[AccW-1:16];
        rnd_res = r_acc[AccW-1] ? (~rnd_q[VW-1:0] + 1'b1) : rnd_q[VW-1:0];
    end

    // Shared divider and its operand selection.
    logic                    div_start;
    logic [DIVW-1:0]         div_num;
    logic [CntW-1:0]         div_len;
    logic [31:0]             div_den;
    logic [VW-1:0]           div_q;
    evs_pkg::t_div_stat      div_stat;
    logic [PerW-1:0]         per_num;
    logic [32:0]             wgt_num;
    logic [DIVW-1:0]         cnt_num;

    always_comb begin
        per_num = {1'b0, r_tps, {FRACTION_BITS{1'b0}}} + PerW'(r_per >> 1);
        wgt_num = {1'b0, r_dmag[15:0], 16'b0} + 33'(bce >> 1);
        cnt_num = {1'b0, r_prod, {FRACTION_BITS{1'b0}}} + DIVW'(dt >> 1);
        div_start = 1'b0;
        div_num   = cnt_num;
        div_len   = CntW'(DIVW);
        div_den   = dt;
        case (r_state)
            S_PER: begin
                div_start = per_ok;
                div_num   = {per_num, {(DIVW-PerW){1'b0}}};
                div_len   = CntW'(PerW);
                div_den   = r_per;
            end
            S_CNT: begin
                div_start = dt != '0;
            end
            S_WGT: begin
                div_start = per_ok && (r_dmag < {16'b0, bce});
                div_num   = {wgt_num, {(DIVW-33){1'b0}}};
                div_len   = CntW'(33);
                div_den   = {16'b0, bce};
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    evs_div #(.DIVW(DIVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_len      (div_len),
        .i_divisor  (div_den),
        .o_quot     (div_q),
        .o_stat     (div_stat)
    );

    logic out_free;
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_in_ready  = r_state == S_IDLE;
    // Registers change only between requests.
    assign o_cfg_ready = r_state == S_IDLE;

    // Sequencer and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tps     <= 32'd1000000;
            r_stop    <= 31'd500000;
            r_wl      <= 32'd20000;
            r_bc      <= 16'd100;
            r_wstart  <= '0;
            r_wcount  <= '0;
            r_blended <= '0;
            r_has     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    evs_pkg::RegTicksPerSec: r_tps  <= i_cfg_data;
                    evs_pkg::RegStopTimeout: r_stop <= i_cfg_data[30:0];
                    evs_pkg::RegWindowLen:   r_wl   <= i_cfg_data;
                    evs_pkg::RegBlendCounts: r_bc   <= i_cfg_data[15:0];
                    default: r_bc <= r_bc;
                endcase
            end
            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_PER;
                S_PER:   r_state <= per_ok ? S_PWAIT : S_PROD;
                S_PWAIT: if (div_stat.done) r_state <= S_PROD;
                S_PROD:  r_state <= elapsed ? S_CNT : S_FIN;
                S_CNT:   r_state <= (dt != '0) ? S_CWAIT : S_WGT;
                S_CWAIT: if (div_stat.done) r_state <= S_WGT;
                S_WGT: begin
                    if (!per_ok) r_state <= S_FIN;
                    else if (div_start) r_state <= S_WWAIT;
                    else r_state <= S_MINIT;
                end
                S_WWAIT: if (div_stat.done) r_state <= S_MINIT;
                S_MINIT: r_state <= S_MUL;
                S_MUL:   if (r_mcnt == 5'd16) r_state <= S_RND;
                S_RND:   r_state <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        r_state  <= S_IDLE;
                        if (!started) begin
                            r_wstart <= r_nus;
                            r_wcount <= r_pos;
                            if (per_ok) begin
                                r_blended <= r_vper;
                                r_has     <= 1'b1;
                            end
                        end else if (elapsed) begin
                            r_blended <= per_ok ? r_blend : r_vcnt;
                            r_has     <= 1'b1;
                            r_wstart  <= r_nus;
                            r_wcount  <= r_pos;
                        end else begin
                            if ((r_has || per_ok) && stale) begin
                                r_blended <= '0;
                            end else if (!r_has && per_ok) begin
                                r_blended <= r_vper;
                            end
                            if (per_ok) r_has <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_nt   <= i_now_ticks;
            r_nus  <= i_now_us;
            r_edge <= i_last_edge_ticks;
            r_per  <= i_last_period_ticks;
            r_dir  <= i_edge_direction;
            r_pos  <= i_position_count;
            r_vper <= '0;
            r_vcnt <= '0;
        end
        if (r_state == S_PWAIT && div_stat.done) begin
            r_vper <= evs_pkg::sat_vel(r_dir[1], div_stat.ovf, div_q);
        end
        if (r_state == S_PROD) begin
            r_dmag <= dmag;
            r_dneg <= dc[31];
            r_prod <= evs_pkg::ProdW'({19'b0, dmag} * {31'b0, evs_pkg::UsPerSec});
        end
        if (r_state == S_CWAIT && div_stat.done) begin
            r_vcnt <= evs_pkg::sat_vel(r_dneg, div_stat.ovf, div_q);
        end
        if (r_state == S_WGT) begin
            r_a <= evs_pkg::WeightOne;
        end else if (r_state == S_WWAIT && div_stat.done) begin
            r_a <= div_q[evs_pkg::WgtW-1:0];
        end
        // Blend as v_per * 1.0 + (v_cnt - v_per) * a, one weight bit per cycle.
        if (r_state == S_MINIT) begin
            r_acc  <= {{(AccW-VW-16){r_vper[VW-1]}}, r_vper, 16'b0};
            r_md   <= {{(AccW-VW-1){vdiff[VW]}}, vdiff};
            r_mcnt <= '0;
        end else if (r_state == S_MUL) begin
            if (r_a[0]) r_acc <= r_acc + r_md;
            r_md   <= r_md << 1;
            r_a    <= r_a >> 1;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (r_state == S_RND) begin
            r_blend <= rnd_res;
        end
        if (r_state == S_FIN && out_free) begin
            if (!started) begin
                r_ovel <= per_ok ? r_vper : '0;
                r_ovv  <= per_ok;
            end else if (elapsed) begin
                r_ovel <= per_ok ? r_blend : r_vcnt;
                r_ovv  <= 1'b1;
            end else begin
                if ((r_has || per_ok) && stale) r_ovel <= '0;
                else if (r_has) r_ovel <= r_blended;
                else r_ovel <= per_ok ? r_vper : '0;
                r_ovv <= r_has || per_ok;
            end
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_velocity       = r_ovel;
    assign o_velocity_valid = r_ovv;

    `EVS_ASSERT(a_one_request, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "request accepted while one is in work")
    `EVS_ASSERT(a_div_idle, i_clk, i_rst_n, div_start |-> !div_stat.busy, "divider restarted while busy")
    `EVS_ASSERT(a_invalid_zero, i_clk, i_rst_n, (o_out_valid && !o_velocity_valid) |-> (o_velocity == '0), "invalid result with nonzero velocity")
    `EVS_ASSERT(a_wait_done, i_clk, i_rst_n, (r_state == S_PWAIT && !div_stat.done) |-> div_stat.busy, "waiting on an idle divider")

endmodule
`default_nettype wire

FILE: tb/sv/encoder_velocity_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder velocity estimator testbench
// Drives velocity reads and register writes through valid/ready handshakes.
// A local model predicts each velocity, and a checker compares the results
// in order. Directed corner cases run first, then random encoder traffic
// under several register settings, random idling and a long output stall.
// ----------------------------------------------------------------------------
module encoder_velocity_estimator_tb;

    localparam longint VMAX       = 64'sh7FFF_FFFF_FFFF;
    localparam longint VMIN       = -VMAX - 1;
    localparam int     CYCLE_CAP  = 1200000;
    localparam int     DRAIN_WAIT = 200;

    typedef struct {
        logic [31:0] now_ticks;
        logic [31:0] now_us;
        logic [31:0] last_edge;
        logic [31:0] period;
        logic [1:0]  dir;
        logic [31:0] pos;
    } read_t;

    typedef struct {
        logic [47:0] vel;
        logic        ok;
    } vel_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [31:0] i_now_ticks = '0;
    logic [31:0] i_now_us = '0;
    logic [31:0] i_last_edge_ticks = '0;
    logic [31:0] i_last_period_ticks = '0;
    logic signed [1:0]  i_edge_direction = '0;
    logic signed [31:0] i_position_count = '0;
    logic        i_out_ready = 1'b0;
    logic        o_cfg_ready, o_in_ready, o_out_valid, o_velocity_valid;
    logic signed [47:0] o_velocity;

    encoder_velocity_estimator dut (.*);

    // Predictor state and register copies.
    logic [31:0] tick_rate, stop_ticks, win_len, blend_cnt;
    logic [31:0] win_start_us, win_start_pos;
    longint      blend_vel;
    bit          have_est;

    vel_t        velocity_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;
    logic [31:0] sim_us, sim_ticks, sim_pos;

    initial forever #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        error_count++;
    endtask

    function automatic longint clamp_vel(input bit neg, input logic [63:0] mag);
        if (neg) return (mag >= 64'h8000_0000_0000) ? VMIN : -longint'(mag);
        return (mag > 64'h7FFF_FFFF_FFFF) ? VMAX : longint'(mag);
    endfunction

    function automatic vel_t predict_velocity(input read_t rd);
        vel_t        res;
        bit          stale, per_ok, neg;
        longint      v_per, v_cnt;
        logic [63:0] mag, prod, quo, rem, sum;
        logic [31:0] dt, dc, dmag, bc, wgt;
        v_per = 0;
        res.vel = '0;
        res.ok = 1'b0;
        stale = (rd.last_edge == 0) || ((rd.now_ticks - rd.last_edge) > stop_ticks);
        per_ok = !stale && rd.period != 0 && rd.dir != 0;
        if (per_ok) begin
            mag = (({32'd0, tick_rate} << 16) + 64'(rd.period / 2)) / 64'(rd.period);
            v_per = clamp_vel(rd.dir[1], mag);
        end
        if (win_start_us == 0) begin
            win_start_us = rd.now_us;
            win_start_pos = rd.pos;
            if (per_ok) begin
                blend_vel = v_per;
                have_est = 1'b1;
                res.vel = v_per[47:0];
                res.ok = 1'b1;
            end
        end else begin
            dt = rd.now_us - win_start_us;
            dc = rd.pos - win_start_pos;
            if (dt >= win_len) begin
                neg = dc[31];
                dmag = neg ? -dc : dc;
                v_cnt = 0;
                if (dt != 0) begin
                    prod = 64'(dmag) * 64'd1000000;
                    quo = prod / 64'(dt);
                    rem = prod % 64'(dt);
                    if (quo > 64'h7FFF_FFFF) mag = 64'h8000_0000_0001;
                    else mag = (quo << 16) + (((rem << 16) * 2 + 64'(dt)) / (2 * 64'(dt)));
                    v_cnt = clamp_vel(neg, mag);
                end
                if (!per_ok) begin
                    blend_vel = v_cnt;
                end else begin
                    bc = (blend_cnt == 0) ? 32'd1 : blend_cnt;
                    if (dmag >= bc) wgt = 32'd65536;
                    else wgt = 32'((64'(dmag) * 65536 + 64'(bc / 2)) / 64'(bc));
                    sum = 64'(v_cnt * longint'(wgt)) + 64'(v_per * longint'(65536 - wgt));
                    mag = sum[63] ? -sum : sum;
                    mag = (mag + 64'd32768) >> 16;
                    blend_vel = sum[63] ? -longint'(mag) : longint'(mag);
                end
                have_est = 1'b1;
                win_start_us = rd.now_us;
                win_start_pos = rd.pos;
            end else begin
                if (!have_est && per_ok) begin
                    blend_vel = v_per;
                    have_est = 1'b1;
                end
                if (have_est && stale) blend_vel = 0;
            end
            if (have_est) begin
                res.vel = blend_vel[47:0];
                res.ok = 1'b1;
            end
        end
        return res;
    endfunction

    // Output side: ready with random idling, plus a counted hold-off on request.
    always @(posedge i_clk) begin
        vel_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (velocity_q.size() == 0) begin
                report("result with nothing expected");
            end else begin
                want = velocity_q.pop_front();
                if (o_velocity_valid !== want.ok)
                    report($sformatf("valid %b, expected %b", o_velocity_valid, want.ok));
                if (o_velocity !== want.vel)
                    report($sformatf("velocity %h, expected %h", o_velocity, want.vel));
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= idle_on ? ($urandom_range(0, 99) >= 38) : 1'b1;
        end
    end

    // Sends one read; valid stays high afterwards until stop_reads or the next read.
    task automatic send_read(input read_t rd);
        if (idle_on && $urandom_range(0, 99) < 38) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ticks <= rd.now_ticks;
        i_now_us <= rd.now_us;
        i_last_edge_ticks <= rd.last_edge;
        i_last_period_ticks <= rd.period;
        i_edge_direction <= rd.dir;
        i_position_count <= rd.pos;
        do @(posedge i_clk); while (!o_in_ready);
        velocity_q.push_back(predict_velocity(rd));
    endtask

    task automatic stop_reads();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_of(input logic [31:0] tk, us, edg, per, input logic [1:0] dir,
                           input logic [31:0] pos);
        read_t rd;
        rd = '{tk, us, edg, per, dir, pos};
        send_read(rd);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        stop_reads();
        while (velocity_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            evs_pkg::RegTicksPerSec: tick_rate = data;
            evs_pkg::RegStopTimeout: stop_ticks = {1'b0, data[30:0]};
            evs_pkg::RegWindowLen:   win_len = data;
            evs_pkg::RegBlendCounts: blend_cnt = {16'd0, data[15:0]};
            default: ;
        endcase
    endtask

    // Mostly plausible encoder motion, with some fully random noise reads.
    function automatic read_t next_read();
        read_t rd;
        int    span;
        if ($urandom_range(0, 99) < 20) begin
            rd = '{$urandom, $urandom, $urandom, $urandom, 2'($urandom), $urandom};
            return rd;
        end
        span = (win_len > 40000) ? 40000 : int'(win_len) + 2;
        sim_us += $urandom_range(0, span);
        sim_ticks += $urandom_range(0, 60000);
        sim_pos += $urandom_range(0, 600) - 300;
        rd.now_ticks = sim_ticks;
        rd.now_us = sim_us;
        rd.last_edge = sim_ticks - $urandom_range(0, (stop_ticks > 800000) ? 1000000
                                                   : int'(stop_ticks) * 5 / 4 + 1);
        if ($urandom_range(0, 19) == 0) rd.last_edge = 0;
        rd.period = ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom_range(1, 200000);
        rd.dir = 2'($urandom_range(0, 3));
        rd.pos = sim_pos;
        return rd;
    endfunction

    task automatic test_defaults();
        read_of(1000, 0, 900, 500, 2'b01, 0);            // start at time zero stays unstarted
        read_of(2000, 100, 1900, 700, 2'b00, 5);         // window starts, no period estimate
        read_of(3000, 200, 0, 700, 2'b01, 9);            // no edge yet: stale forces zero
        read_of(4000, 300, 3900, 400, 2'b01, 12);        // running window, fresh period
        read_of(5000, 30000, 4900, 250, 2'b10, 60);      // window elapsed, reverse as -2
        read_of(6000, 60000, 5999, 1, 2'b11, 32'h8000_0000);
        read_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'b01,
                32'h7FFF_FFFF);
        read_of(32'd5, 32'd10, 32'hFFFF_FFF0, 32'd2, 2'b01, 32'h8000_0001);  // tick wrap
        read_of(900000, 100000, 100, 1000, 2'b01, 0);    // stale by age
    endtask

    task automatic test_register_extremes();
        write_reg(evs_pkg::RegWindowLen, 0);             // zero elapsed time
        read_of(100, 100000, 90, 300, 2'b01, 7);
        read_of(200, 100000, 190, 300, 2'b01, 7);
        write_reg(evs_pkg::RegBlendCounts, 0);
        read_of(300, 100001, 290, 300, 2'b11, 9);
        write_reg(evs_pkg::RegTicksPerSec, 0);
        read_of(400, 100500, 390, 300, 2'b01, 40);
        write_reg(evs_pkg::RegTicksPerSec, 32'hFFFF_FFFF);
        write_reg(evs_pkg::RegStopTimeout, 32'h7FFF_FFFF);
        read_of(500, 100600, 32'h8000_0200, 1, 2'b01, 41);
        read_of(600, 100700, 590, 1, 2'b10, 32'hC000_0000);
        write_reg(evs_pkg::RegStopTimeout, 0);
        read_of(700, 100800, 700, 3, 2'b01, 50);
        read_of(800, 100900, 799, 3, 2'b01, 51);
        write_reg(evs_pkg::RegWindowLen, 32'hFFFF_FFFF);
        write_reg(evs_pkg::RegBlendCounts, 16'hFFFF);
        read_of(900, 101000, 900, 3, 2'b01, 60);
        read_of(1000, 101000, 1000, 3, 2'b01, 62);
    endtask

    task automatic test_random_traffic();
        logic [31:0] settings[6][4] = '{
            '{1000000, 500000, 20000, 100},
            '{1, 1000, 1, 1},
            '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 65535},
            '{48000000, 200000, 5000, 10},
            '{12345, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0},
            '{20000000, 40000, 1000, 500}};
        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 4; r++) write_reg(2'(r), settings[ph][r]);
            idle_on = (ph != 3);
            for (int n = 0; n < 190; n++) send_read(next_read());
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        stop_reads();
        while (velocity_q.size() != 0) @(posedge i_clk);
        stall_left = 500;
        for (int n = 0; n < 30; n++) send_read(next_read());
    endtask

    initial begin
        tick_rate = 1000000;
        stop_ticks = 500000;
        win_len = 20000;
        blend_cnt = 100;
        win_start_us = 0;
        win_start_pos = 0;
        blend_vel = 0;
        have_est = 1'b0;
        sim_us = $urandom;
        sim_ticks = $urandom;
        sim_pos = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();

        stop_reads();
        while (velocity_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/evs_pkg.sv
hdl/evs_div.sv
hdl/encoder_velocity_estimator.sv
tb/sv/encoder_velocity_estimator_tb.sv
